// File: rtl/core/vvfs_pkg.sv
// voxel visible face scan: shared types and codes
// request payload types for the input, result and configuration channels
// no dependencies
package vvfs_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCAN  = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [3:0] pos_x;
    logic [5:0] pos_y;
    logic [3:0] pos_z;
    logic [7:0] voxel_type;
  } vvfs_in_t;

  typedef struct packed {
    logic [5:0] face_mask;
    logic [3:0] cell_x;
    logic [5:0] cell_y;
    logic [3:0] cell_z;
    logic [7:0] cell_type;
    logic       last_voxel;
  } vvfs_out_t;

  typedef logic [7:0] vvfs_cfg_t;

endpackage

// File: rtl/core/vvfs_chan_if.sv
// valid/ready channel carrying one request payload
// payload type is set per instance; depends on nothing
interface vvfs_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/vvfs_ram.sv
// generic single-port synchronous ram, registered read
// used for the voxel store; depends on nothing
module vvfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/voxel_visible_face_scan_unit.sv
// channel  | dir | payload     | purpose
// in_chan  | in  | vvfs_in_t   | voxel write or scan-next request
// out_chan | out | vvfs_out_t  | face mask, position and type of scanned voxel
// cfg_chan | in  | vvfs_cfg_t  | air type code, always ready
//
// a write request is written in the cycle it is accepted, if in range. a scan
// request makes seven reads (voxel, then its six neighbors), one per cycle
// through the single ram port, then the result is loaded into the output register.
// synchronous active-low reset clears control state and the scan position;
// the voxel store is not cleared. a stalled output only holds the block in
// its final scan cycle; the output register frees the input side otherwise.
// depends on vvfs_pkg, vvfs_chan_if, vvfs_ram
module voxel_visible_face_scan_unit
  import vvfs_pkg::*;
#(
  parameter int CHUNK_WIDTH  = 16,
  parameter int CHUNK_HEIGHT = 64,
  parameter int TYPE_BITS    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  vvfs_chan_if.sink   in_chan,
  vvfs_chan_if.source out_chan,
  vvfs_chan_if.sink   cfg_chan
);

  localparam int VOXELS = CHUNK_WIDTH * CHUNK_WIDTH * CHUNK_HEIGHT;
  localparam int AW     = $clog2(VOXELS);
  localparam int XW     = $clog2(CHUNK_WIDTH);
  localparam int YW     = $clog2(CHUNK_HEIGHT);
  localparam int CW     = (TYPE_BITS > 8) ? TYPE_BITS : 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [2:0]           step_r, step_nxt;
  logic [XW-1:0]        scan_x_r, scan_x_nxt;
  logic [XW-1:0]        scan_z_r, scan_z_nxt;
  logic [YW-1:0]        scan_y_r, scan_y_nxt;
  logic [AW-1:0]        scan_addr_r, scan_addr_nxt;
  logic [TYPE_BITS-1:0] type_r, type_nxt;
  logic [5:0]           mask_r, mask_nxt;
  logic [7:0]           air_type_r, air_type_nxt;
  vvfs_out_t            out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [TYPE_BITS-1:0] ram_wdata;
  logic [TYPE_BITS-1:0] ram_rdata;

  logic                 in_acc;
  logic                 out_load;
  logic                 wr_in_range;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [5:0]           edge_v;
  logic                 rd_is_air;
  logic [2:0]           face_idx;

  vvfs_ram #(
    .WIDTH (TYPE_BITS),
    .DEPTH (VOXELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_chan.ready    = (state_r == S_IDLE);
  assign cfg_chan.ready   = 1'b1;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  assign wr_in_range = (32'(in_chan.payload.pos_x) < CHUNK_WIDTH) &&
                       (32'(in_chan.payload.pos_y) < CHUNK_HEIGHT) &&
                       (32'(in_chan.payload.pos_z) < CHUNK_WIDTH);
  assign wr_addr = AW'((32'(in_chan.payload.pos_y) * CHUNK_WIDTH +
                        32'(in_chan.payload.pos_z)) * CHUNK_WIDTH +
                       32'(in_chan.payload.pos_x));

  // faces on the chunk boundary are always visible
  assign edge_v[0] = (scan_x_r == '0);
  assign edge_v[1] = (scan_x_r == XW'(CHUNK_WIDTH - 1));
  assign edge_v[2] = (scan_y_r == '0);
  assign edge_v[3] = (scan_y_r == YW'(CHUNK_HEIGHT - 1));
  assign edge_v[4] = (scan_z_r == '0);
  assign edge_v[5] = (scan_z_r == XW'(CHUNK_WIDTH - 1));

  // read order: voxel, -x, +x, -y, +y, -z, +z; edge neighbors reread the voxel
  always_comb begin
    case (step_r)
      3'd1:    rd_addr = edge_v[0] ? scan_addr_r : scan_addr_r - AW'(1);
      3'd2:    rd_addr = edge_v[1] ? scan_addr_r : scan_addr_r + AW'(1);
      3'd3:    rd_addr = edge_v[2] ? scan_addr_r
                                   : scan_addr_r - AW'(CHUNK_WIDTH * CHUNK_WIDTH);
      3'd4:    rd_addr = edge_v[3] ? scan_addr_r
                                   : scan_addr_r + AW'(CHUNK_WIDTH * CHUNK_WIDTH);
      3'd5:    rd_addr = edge_v[4] ? scan_addr_r : scan_addr_r - AW'(CHUNK_WIDTH);
      3'd6:    rd_addr = edge_v[5] ? scan_addr_r : scan_addr_r + AW'(CHUNK_WIDTH);
      default: rd_addr = scan_addr_r;
    endcase
  end

  assign rd_is_air = (CW'(ram_rdata) == CW'(air_type_r));
  assign face_idx  = step_r - 3'd2;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    scan_x_nxt    = scan_x_r;
    scan_z_nxt    = scan_z_r;
    scan_y_nxt    = scan_y_r;
    scan_addr_nxt = scan_addr_r;
    type_nxt      = type_r;
    mask_nxt      = mask_r;
    air_type_nxt  = air_type_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_addr      = rd_addr;
    ram_wdata     = TYPE_BITS'(in_chan.payload.voxel_type);

    if (cfg_chan.valid && cfg_chan.ready) begin
      air_type_nxt = cfg_chan.payload;
    end
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        ram_addr = wr_addr;
        if (in_acc) begin
          if (in_chan.payload.operation == OP_WRITE) begin
            ram_we = wr_in_range;
          end else begin
            state_nxt = S_READ;
            step_nxt  = 3'd0;
          end
        end
      end
      S_READ: begin
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          state_nxt = S_DONE;
        end
        // data of the read issued one step earlier
        if (step_r == 3'd1) begin
          type_nxt = ram_rdata;
        end else if (step_r >= 3'd2) begin
          mask_nxt[face_idx] = edge_v[face_idx] || rd_is_air;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt      = 1'b1;
          out_nxt.face_mask  = (CW'(type_r) != CW'(air_type_r)) ? mask_r : 6'd0;
          out_nxt.cell_x     = 4'(scan_x_r);
          out_nxt.cell_y     = 6'(scan_y_r);
          out_nxt.cell_z     = 4'(scan_z_r);
          out_nxt.cell_type  = 8'(type_r);
          out_nxt.last_voxel = (scan_addr_r == AW'(VOXELS - 1));
          state_nxt          = S_IDLE;
          // x fastest, then z, then y, wrapping at the end of the chunk
          if (scan_addr_r == AW'(VOXELS - 1)) begin
            scan_addr_nxt = '0;
          end else begin
            scan_addr_nxt = scan_addr_r + AW'(1);
          end
          if (scan_x_r == XW'(CHUNK_WIDTH - 1)) begin
            scan_x_nxt = '0;
            if (scan_z_r == XW'(CHUNK_WIDTH - 1)) begin
              scan_z_nxt = '0;
              if (scan_y_r == YW'(CHUNK_HEIGHT - 1)) begin
                scan_y_nxt = '0;
              end else begin
                scan_y_nxt = scan_y_r + YW'(1);
              end
            end else begin
              scan_z_nxt = scan_z_r + XW'(1);
            end
          end else begin
            scan_x_nxt = scan_x_r + XW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 3'd0;
      scan_x_r    <= '0;
      scan_z_r    <= '0;
      scan_y_r    <= '0;
      scan_addr_r <= '0;
      air_type_r  <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      scan_x_r    <= scan_x_nxt;
      scan_z_r    <= scan_z_nxt;
      scan_y_r    <= scan_y_nxt;
      scan_addr_r <= scan_addr_nxt;
      air_type_r  <= air_type_nxt;
      out_valid_r <= out_valid_nxt;
    end
    type_r <= type_nxt;
    mask_r <= mask_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTH
  a_we_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE))
    else $error("voxel store written outside idle");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_chan.ready) |=> (state_r == S_DONE))
    else $error("scan result dropped while output full");

  a_pos_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !out_load) |=> $stable(scan_addr_r))
    else $error("scan position moved without a result");

  a_pos_match: assert property (@(posedge clk) disable iff (!rst_n)
    32'(scan_addr_r) == (32'(scan_y_r) * CHUNK_WIDTH + 32'(scan_z_r)) * CHUNK_WIDTH
                        + 32'(scan_x_r))
    else $error("scan address and coordinates disagree");
`endif

endmodule
